// ===== rtl/multilevel_ready_queue_scheduler_defines.svh =====
// Assertion macros shared by the scheduler modules.
`ifndef MULTILEVEL_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_READY_QUEUE_SCHEDULER_DEFINES_SVH

// Immediate implication: when the condition holds, the check holds.
`define MRQ_ASSERT_IMP(lbl, clk, rstn, cond, chk, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (chk)) \
    else $error(msg);

// Next-cycle implication.
`define MRQ_ASSERT_NEXT(lbl, clk, rstn, cond, chk, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (chk)) \
    else $error(msg);

`endif

// ===== rtl/mrqs_pkg.sv =====
`default_nettype none
package mrqs_pkg;
  localparam int unsigned LevelsDef     = 5;
  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned IdW           = 32;
  localparam int unsigned PrioW         = 4;

  typedef enum logic [1:0] {
    OpEnqueue = 2'd0,
    OpPick    = 2'd1,
    OpRemove  = 2'd2,
    OpUnused  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNone    = 2'd1,
    StBadPrio = 2'd2,
    StFull    = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture request fields
    logic lvl_first;  // point the level pointer at level zero, or at the priority when loading it
    logic lvl_next;   // advance the level pointer
    logic pos_first;  // point the position counter at zero
    logic pos_next;   // advance the position counter
    logic rd;         // read the slot at the level pointer and position
    logic wr_enq;     // write the request id at the tail
    logic wr_shift;   // write the read data one slot back
    logic occ_inc;    // enqueue bookkeeping
    logic pop;        // pick bookkeeping at the current level
    logic served_clr; // clear served count at the current level
    logic occ_dec;    // remove bookkeeping
    logic done;       // present the result
    status_e st;      // status of the result
    logic pass_id;    // show the read data as chosen id
    logic req_id;     // show the request id as chosen id
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic prio_bad;
    logic full;
    logic lvl_ready;  // served below occupancy at current level
    logic lvl_last;
    logic pos_end;    // position reached occupancy
    logic pos_last;   // position is occupancy minus one
    logic match;      // read data equals request id
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/mrqs_ram.sv =====
`default_nettype none
module mrqs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/mrqs_datapath.sv =====
`default_nettype none
`include "multilevel_ready_queue_scheduler_defines.svh"
module mrqs_datapath #(
  parameter int unsigned Levels     = mrqs_pkg::LevelsDef,
  parameter int unsigned QueueDepth = mrqs_pkg::QueueDepthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [mrqs_pkg::IdW-1:0]    task_id_i,
  input  wire logic [mrqs_pkg::PrioW-1:0]  priority_req_i,
  input  wire mrqs_pkg::ctl_cmd_t          cmd_i,
  output mrqs_pkg::dp_stat_t               stat_o,
  output logic                             result_valid_o,
  output logic [mrqs_pkg::IdW-1:0]         chosen_task_o,
  output logic [1:0]                       status_o
);
  localparam int unsigned LvlW  = $clog2(Levels);
  localparam int unsigned SlotW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW = $clog2(Levels * QueueDepth);
  localparam logic [CntW-1:0] DepthC = CntW'(QueueDepth);

  logic [1:0]                 op_q;
  logic [mrqs_pkg::IdW-1:0]   id_q;
  logic [mrqs_pkg::PrioW-1:0] prio_q;
  logic [LvlW-1:0]            lvl_q;
  logic [CntW-1:0]            pos_q;
  logic [SlotW-1:0]           head_q [Levels];
  logic [CntW-1:0]            occ_q  [Levels];
  logic [CntW-1:0]            srv_q  [Levels];
  logic [mrqs_pkg::IdW-1:0]   rdata;
  logic [AddrW-1:0]           raddr, waddr;
  logic [SlotW-1:0]           rslot, wslot;
  logic [mrqs_pkg::IdW-1:0]   wdata;
  logic                       we;
  logic [CntW-1:0]            occ_cur;
  logic                       res_v_q;
  logic [mrqs_pkg::IdW-1:0]   res_id_q;
  logic [1:0]                 res_st_q;
  logic                       prio_in_range;

  assign occ_cur = occ_q[lvl_q];

  // A priority outside the level range never reaches the level pointer.
  assign prio_in_range = {1'b0, priority_req_i} < (mrqs_pkg::PrioW+1)'(Levels);

  // Ring slot arithmetic: depth may be any value, so wrap by compare.
  function automatic logic [SlotW-1:0] wrap_add(input logic [SlotW-1:0] h,
                                                input logic [CntW-1:0] p);
    logic [CntW:0] s;
    s = {1'b0, CntW'(h)} + {1'b0, p};
    if (s >= (CntW+1)'(QueueDepth)) begin
      s = s - (CntW+1)'(QueueDepth);
    end
    return s[SlotW-1:0];
  endfunction

  assign rslot = wrap_add(head_q[lvl_q], pos_q);
  // Enqueue writes at the tail; shifts write one slot behind the read.
  assign wslot = cmd_i.wr_enq ? wrap_add(head_q[lvl_q], occ_cur)
                              : wrap_add(head_q[lvl_q], pos_q - CntW'(1));
  assign raddr = AddrW'(lvl_q) * AddrW'(QueueDepth) + AddrW'(rslot);
  assign waddr = AddrW'(lvl_q) * AddrW'(QueueDepth) + AddrW'(wslot);
  assign we    = cmd_i.wr_enq | cmd_i.wr_shift;
  assign wdata = cmd_i.wr_enq ? id_q : rdata;

  mrqs_ram #(.Width(mrqs_pkg::IdW), .Depth(Levels * QueueDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    stat_o.op        = mrqs_pkg::op_e'(op_q);
    stat_o.prio_bad  = {1'b0, prio_q} >= (mrqs_pkg::PrioW+1)'(Levels);
    stat_o.full      = occ_cur >= DepthC;
    stat_o.lvl_ready = srv_q[lvl_q] < occ_cur;
    stat_o.lvl_last  = lvl_q == LvlW'(Levels - 1);
    stat_o.pos_end   = pos_q >= occ_cur;
    stat_o.pos_last  = (pos_q + CntW'(1)) >= occ_cur;
    stat_o.match     = rdata == id_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      id_q   <= task_id_i;
      prio_q <= priority_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q    <= '0;
      pos_q    <= '0;
      res_v_q  <= 1'b0;
      res_id_q <= '0;
      res_st_q <= '0;
      for (int i = 0; i < Levels; i++) begin
        head_q[i] <= '0;
        occ_q[i]  <= '0;
        srv_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.lvl_first) begin
        lvl_q <= (cmd_i.load && prio_in_range) ? LvlW'(priority_req_i) : '0;
      end else if (cmd_i.lvl_next) begin
        lvl_q <= lvl_q + LvlW'(1);
      end
      if (cmd_i.pos_first) begin
        pos_q <= '0;
      end else if (cmd_i.pos_next) begin
        pos_q <= pos_q + CntW'(1);
      end
      if (cmd_i.occ_inc) begin
        occ_q[lvl_q] <= occ_cur + CntW'(1);
      end
      if (cmd_i.occ_dec) begin
        occ_q[lvl_q] <= occ_cur - CntW'(1);
      end
      if (cmd_i.pop) begin
        head_q[lvl_q] <= wrap_add(head_q[lvl_q], CntW'(1));
        occ_q[lvl_q]  <= occ_cur - CntW'(1);
        srv_q[lvl_q]  <= srv_q[lvl_q] + CntW'(1);
      end
      if (cmd_i.served_clr) begin
        srv_q[lvl_q] <= '0;
      end
      res_v_q <= cmd_i.done;
      if (cmd_i.done) begin
        res_st_q <= cmd_i.st;
        res_id_q <= cmd_i.pass_id ? rdata : (cmd_i.req_id ? id_q : '0);
      end
    end
  end

  assign result_valid_o = res_v_q;
  assign chosen_task_o  = res_id_q;
  assign status_o       = res_st_q;

  `MRQ_ASSERT_IMP(a_occ_le_depth, clk_i, rst_ni, 1'b1, occ_cur <= DepthC,
    "occupancy above queue depth")
  `MRQ_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, cmd_i.pop, occ_cur != '0,
    "pop from an empty level")
  `MRQ_ASSERT_IMP(a_enq_not_full, clk_i, rst_ni, cmd_i.wr_enq, !stat_o.full,
    "enqueue into a full level")
endmodule
`default_nettype wire

// ===== rtl/mrqs_ctrl.sv =====
`default_nettype none
`include "multilevel_ready_queue_scheduler_defines.svh"
module mrqs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire mrqs_pkg::dp_stat_t stat_i,
  output mrqs_pkg::ctl_cmd_t      cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_PICK, S_PICK_RD, S_PICK_OUT, S_RM_RD, S_RM_CMP, S_RM_SHRD,
    S_RM_SHIFT
  } state_e;

  state_e state_q, state_d;
  logic   pass_q, pass_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load      = 1'b1;
          cmd_o.lvl_first = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.op)
          mrqs_pkg::OpEnqueue: begin
            cmd_o.done = 1'b1;
            state_d    = S_IDLE;
            if (stat_i.prio_bad) begin
              cmd_o.st = mrqs_pkg::StBadPrio;
            end else if (stat_i.full) begin
              cmd_o.st = mrqs_pkg::StFull;
            end else begin
              cmd_o.st      = mrqs_pkg::StOk;
              cmd_o.wr_enq  = 1'b1;
              cmd_o.occ_inc = 1'b1;
            end
          end
          mrqs_pkg::OpPick: begin
            // Level pointer was loaded with the priority; restart at zero.
            cmd_o.lvl_first = 1'b1;
            cmd_o.pos_first = 1'b1;
            pass_d          = 1'b0;
            state_d         = S_PICK;
          end
          mrqs_pkg::OpRemove: begin
            if (stat_i.prio_bad) begin
              cmd_o.done = 1'b1;
              cmd_o.st   = mrqs_pkg::StBadPrio;
              state_d    = S_IDLE;
            end else begin
              cmd_o.pos_first = 1'b1;
              state_d         = S_RM_RD;
            end
          end
          default: begin
            cmd_o.done = 1'b1;
            cmd_o.st   = mrqs_pkg::StNone;
            state_d    = S_IDLE;
          end
        endcase
      end
      S_PICK: begin
        if (stat_i.lvl_ready) begin
          cmd_o.rd = 1'b1;
          state_d  = S_PICK_RD;
        end else begin
          cmd_o.served_clr = 1'b1;
          if (stat_i.lvl_last) begin
            cmd_o.lvl_first = 1'b1;
            if (pass_q) begin
              cmd_o.done = 1'b1;
              cmd_o.st   = mrqs_pkg::StNone;
              state_d    = S_IDLE;
            end else begin
              pass_d = 1'b1;
            end
          end else begin
            cmd_o.lvl_next = 1'b1;
          end
        end
      end
      S_PICK_RD: begin
        state_d = S_PICK_OUT;
      end
      S_PICK_OUT: begin
        cmd_o.pop     = 1'b1;
        cmd_o.done    = 1'b1;
        cmd_o.st      = mrqs_pkg::StOk;
        cmd_o.pass_id = 1'b1;
        state_d       = S_IDLE;
      end
      S_RM_RD: begin
        if (stat_i.pos_end) begin
          cmd_o.done = 1'b1;
          cmd_o.st   = mrqs_pkg::StNone;
          state_d    = S_IDLE;
        end else begin
          state_d = S_RM_CMP;
        end
      end
      S_RM_CMP: begin
        if (stat_i.match) begin
          if (stat_i.pos_last) begin
            cmd_o.occ_dec = 1'b1;
            cmd_o.done    = 1'b1;
            cmd_o.st      = mrqs_pkg::StOk;
            cmd_o.req_id  = 1'b1;
            state_d       = S_IDLE;
          end else begin
            cmd_o.pos_next = 1'b1;
            state_d        = S_RM_SHRD;
          end
        end else begin
          cmd_o.pos_next = 1'b1;
          state_d        = S_RM_RD;
        end
      end
      S_RM_SHRD: begin
        // The memory reads the entry at pos during this cycle.
        state_d = S_RM_SHIFT;
      end
      S_RM_SHIFT: begin
        // Read data holds entry pos; it moves one slot toward the head.
        cmd_o.wr_shift = 1'b1;
        if (stat_i.pos_last) begin
          cmd_o.occ_dec = 1'b1;
          cmd_o.done    = 1'b1;
          cmd_o.st      = mrqs_pkg::StOk;
          cmd_o.req_id  = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.pos_next = 1'b1;
          state_d        = S_RM_SHRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  assign busy = state_q != S_IDLE;

  `MRQ_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy,
    "accepted request did not raise busy")
  `MRQ_ASSERT_IMP(a_done_idle, clk_i, rst_ni, cmd_o.done, state_d == S_IDLE,
    "result issued without returning to idle")
  `MRQ_ASSERT_IMP(a_one_book, clk_i, rst_ni, 1'b1,
    $onehot0({cmd_o.pop, cmd_o.occ_inc, cmd_o.occ_dec}),
    "conflicting occupancy updates")
endmodule
`default_nettype wire

// ===== rtl/multilevel_ready_queue_scheduler.sv =====
`default_nettype none
// Multilevel ready-queue scheduler with a per-level quota.
// A request is taken at a rising edge where start is high and busy is low;
// opcode_i selects enqueue, pick or remove, with task_id_i and
// priority_req_i as operands. Each request yields exactly one result:
// done_o is high for one cycle with chosen_task_o and status_o valid.
// The receiver cannot stall, so the result is simply driven for that cycle.
// Enqueue and malformed requests are answered from the decode state. A pick
// walks the levels one per cycle and returns status none when both passes
// find nothing. A remove walks its level through the single read port of
// the queue memory: each entry searched takes a read and a compare state,
// and each entry shifted takes a read state and a shift state.
// Busy is low again in the cycle that done_o is high, so the next request
// can be taken at the edge that ends the result cycle. Reset clears all
// heads, occupancies and served counts; queue memory contents are left
// undefined and are only read in the occupied part of a ring, so no
// clearing pass is needed.
module multilevel_ready_queue_scheduler #(
  parameter int unsigned LEVELS      = mrqs_pkg::LevelsDef,
  parameter int unsigned QUEUE_DEPTH = mrqs_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] task_id_i,
  input  wire logic [3:0]  priority_req_i,
  output logic             done_o,
  output logic [31:0]      chosen_task_o,
  output logic [1:0]       status_o
);
  mrqs_pkg::ctl_cmd_t cmd;
  mrqs_pkg::dp_stat_t stat;

  // The controller sequences each request; the datapath holds the rings.
  mrqs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  mrqs_datapath #(.Levels(LEVELS), .QueueDepth(QUEUE_DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (opcode_i),
    .task_id_i      (task_id_i),
    .priority_req_i (priority_req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (done_o),
    .chosen_task_o  (chosen_task_o),
    .status_o       (status_o)
  );
endmodule
`default_nettype wire
